>>> design/sha1_hash_core_unit_defines.svh
// Assertion macros for the checker file of the hash core.
`ifndef SHA1_HASH_CORE_UNIT_DEFINES_SVH
`define SHA1_HASH_CORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SHC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash core check failed");

// Next-cycle implication, disabled while reset is high.
`define SHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash core check failed");

`endif

>>> design/shc_pkg.sv
// Types, constants and round functions shared by the hash core modules.
package shc_pkg;

   // Default depth of the word queue in the front end, ahead of the back end.
   localparam int QUEUE_DEPTH = 4;

   // Rounds per block compression.
   localparam int ROUNDS = 80;

   // First padding byte.
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Input word as seen on the request ports.
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } req_type;

   // Digest word as seen on the response ports.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_result;
   } rsp_type;

   // Classified word held in the queue.
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last_word;
      logic        whole_word;
   } item_type;

   // Initial chaining value for word idx.
   function automatic logic [31:0] init_chain(input logic [2:0] idx);
      logic [31:0] v;
      unique case (idx)
         3'd0:    v = 32'h67452301;
         3'd1:    v = 32'hEFCDAB89;
         3'd2:    v = 32'h98BADCFE;
         3'd3:    v = 32'h10325476;
         default: v = 32'hC3D2E1F0;
      endcase
      return v;
   endfunction

   // Round constant for a round number.
   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] v;
      priority if (rnd < 7'd20) v = 32'h5A827999;
      else if (rnd < 7'd40) v = 32'h6ED9EBA1;
      else if (rnd < 7'd60) v = 32'h8F1BBCDC;
      else v = 32'hCA62C1D6;
      return v;
   endfunction

   // Boolean function of the round.
   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] v;
      priority if (rnd < 7'd20) v = (b & c) | (~b & d);
      else if (rnd < 7'd40) v = b ^ c ^ d;
      else if (rnd < 7'd60) v = (b & c) | (b & d) | (c & d);
      else v = b ^ c ^ d;
      return v;
   endfunction

endpackage

>>> design/shc_front.sv
// Front end: classifies incoming words and queues them for the engine.
module shc_front #(
   parameter int Depth = shc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  shc_pkg::req_type  word_in,
   output logic              full,
   output logic              item_valid,
   output shc_pkg::item_type item,
   input  logic              item_take
);
   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(Depth);

   shc_pkg::item_type mem_ff [Depth];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   shc_pkg::item_type classed;
   logic do_push, do_pop;

   // Clamp the byte count and flag words that carry four bytes.
   always_comb begin
      classed.data_word  = word_in.data_word;
      classed.last_word  = word_in.last_word;
      classed.byte_count = (word_in.valid_bytes > 3'd4) ? 3'd4 : word_in.valid_bytes;
      classed.whole_word = (classed.byte_count == 3'd4);
   end

   assign full       = (count_ff == FULL_COUNT);
   assign item_valid = (count_ff != '0);
   assign item       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= classed;
      end
   end

endmodule

>>> design/shc_back.sv
// Back end: packs bytes into the block buffer, pads, compresses and emits the digest.
module shc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  shc_pkg::item_type item,
   output logic              item_take,
   output logic              rsp_empty,
   output shc_pkg::rsp_type  rsp_data,
   input  logic              rsp_pop
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DATA = 3'd1;
   localparam logic [2:0] ST_PAD  = 3'd2;
   localparam logic [2:0] ST_COMP = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;

   localparam logic [1:0] RES_DATA = 2'd0;
   localparam logic [1:0] RES_PAD  = 2'd1;
   localparam logic [1:0] RES_EMIT = 2'd2;

   localparam logic [6:0] LAST_ROUND = 7'(shc_pkg::ROUNDS);

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  resume_ff, resume_in;
   shc_pkg::item_type item_ff, item_in;
   logic [2:0]  byte_idx_ff, byte_idx_in;
   logic [2:0]  len_idx_ff, len_idx_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [6:0]  round_ff, round_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];

   logic        put_en, put_word, put_resume_set;
   logic [1:0]  put_resume;
   logic [7:0]  put_val;
   logic [5:0]  pos_next;
   logic [31:0] data_shift, wi, w_exp, t_sum;
   logic [63:0] len_shift;

   assign data_shift = item_ff.data_word >> {~byte_idx_ff[1:0], 3'b000};
   assign len_shift  = bitlen_ff >> {~len_idx_ff, 3'b000};
   assign w_exp      = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];
   assign wi         = (round_ff < 7'd16) ? buf_ff[0] : {w_exp[30:0], w_exp[31]};
   assign t_sum      = {a_ff[26:0], a_ff[31:27]} + shc_pkg::round_f(round_ff, b_ff, c_ff, d_ff)
                       + e_ff + shc_pkg::round_k(round_ff) + wi;

   // Sequencer and datapath next state.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      resume_in      = resume_ff;
      item_in        = item_ff;
      byte_idx_in    = byte_idx_ff;
      len_idx_in     = len_idx_ff;
      emit_idx_in    = emit_idx_ff;
      pos_in         = pos_ff;
      bitlen_in      = bitlen_ff;
      round_in       = round_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      chain_in       = chain_ff;
      buf_in         = buf_ff;
      item_take      = 1'b0;
      put_en         = 1'b0;
      put_word       = 1'b0;
      put_val        = '0;
      put_resume     = RES_DATA;
      put_resume_set = 1'b0;
      pos_next       = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take   = 1'b1;
               item_in     = item;
               byte_idx_in = '0;
               state_in    = ST_DATA;
            end
         end
         ST_DATA: begin
            put_resume = RES_DATA;
            if (byte_idx_ff == 3'd0 && item_ff.whole_word && pos_ff[1:0] == 2'b00) begin
               // Aligned four-byte word goes in at once.
               put_en      = 1'b1;
               put_word    = 1'b1;
               byte_idx_in = 3'd4;
               bitlen_in   = bitlen_ff + 64'd32;
            end else if (byte_idx_ff < item_ff.byte_count) begin
               put_en      = 1'b1;
               put_val     = data_shift[7:0];
               byte_idx_in = byte_idx_ff + 1'b1;
               bitlen_in   = bitlen_ff + 64'd8;
            end else if (item_ff.last_word) begin
               state_in = ST_PAD;
               phase_in = PH_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            put_resume = RES_PAD;
            unique case (phase_ff)
               PH_MARK: begin
                  put_en   = 1'b1;
                  put_val  = shc_pkg::PAD_BYTE;
                  phase_in = PH_ZERO;
               end
               PH_ZERO: begin
                  if (pos_ff == 6'd56) begin
                     phase_in   = PH_LEN;
                     len_idx_in = '0;
                  end else begin
                     put_en  = 1'b1;
                     put_val = '0;
                  end
               end
               PH_LEN: begin
                  put_en     = 1'b1;
                  put_val    = len_shift[7:0];
                  len_idx_in = len_idx_ff + 1'b1;
                  if (len_idx_ff == 3'd7) begin
                     put_resume = RES_EMIT;
                  end
               end
               default: begin
                  phase_in = PH_MARK;
               end
            endcase
         end
         ST_COMP: begin
            if (round_ff != LAST_ROUND) begin
               // One round; the buffer doubles as the message schedule window.
               for (int k = 0; k < 15; k++) begin
                  buf_in[k] = buf_ff[k+1];
               end
               buf_in[15] = wi;
               e_in       = d_ff;
               d_in       = c_ff;
               c_in       = {b_ff[1:0], b_ff[31:2]};
               b_in       = a_ff;
               a_in       = t_sum;
               round_in   = round_ff + 1'b1;
            end else begin
               chain_in[0] = chain_ff[0] + a_ff;
               chain_in[1] = chain_ff[1] + b_ff;
               chain_in[2] = chain_ff[2] + c_ff;
               chain_in[3] = chain_ff[3] + d_ff;
               chain_in[4] = chain_ff[4] + e_ff;
               round_in    = '0;
               unique case (resume_ff)
                  RES_DATA: state_in = ST_DATA;
                  RES_PAD:  state_in = ST_PAD;
                  default: begin
                     state_in    = ST_EMIT;
                     emit_idx_in = '0;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               emit_idx_in = emit_idx_ff + 1'b1;
               if (emit_idx_ff == 3'd4) begin
                  for (int k = 0; k < 5; k++) begin
                     chain_in[k] = shc_pkg::init_chain(3'(k));
                  end
                  pos_in    = '0;
                  bitlen_in = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Byte or word write into the block buffer; a full block starts compression.
      if (put_en) begin
         if (put_word) begin
            buf_in[pos_ff[5:2]] = item_ff.data_word;
            pos_next = pos_ff + 6'd4;
         end else begin
            buf_in[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = put_val;
            pos_next = pos_ff + 6'd1;
         end
         pos_in = pos_next;
         if (pos_next == 6'd0) begin
            put_resume_set = 1'b1;
         end
      end
      if (put_resume_set) begin
         resume_in = put_resume;
         state_in  = ST_COMP;
         round_in  = '0;
         a_in = chain_ff[0]; b_in = chain_ff[1]; c_in = chain_ff[2];
         d_in = chain_ff[3]; e_in = chain_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_MARK;
         resume_ff   <= RES_DATA;
         byte_idx_ff <= '0;
         len_idx_ff  <= '0;
         emit_idx_ff <= '0;
         pos_ff      <= '0;
         bitlen_ff   <= '0;
         round_ff    <= '0;
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0; e_ff <= '0;
         for (int k = 0; k < 5; k++) begin
            chain_ff[k] <= shc_pkg::init_chain(3'(k));
         end
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         resume_ff   <= resume_in;
         byte_idx_ff <= byte_idx_in;
         len_idx_ff  <= len_idx_in;
         emit_idx_ff <= emit_idx_in;
         pos_ff      <= pos_in;
         bitlen_ff   <= bitlen_in;
         round_ff    <= round_in;
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
         chain_ff    <= chain_in;
      end
   end

   // Payload registers: current word and block buffer.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      buf_ff  <= buf_in;
   end

   // Digest words are read straight from the chaining registers.
   assign rsp_empty             = (state_ff != ST_EMIT);
   assign rsp_data.digest_word  = chain_ff[emit_idx_ff];
   assign rsp_data.word_index   = emit_idx_ff;
   assign rsp_data.last_result  = (emit_idx_ff == 3'd4);

endmodule

>>> design/sha1_hash_core_unit.sv
// SHA-1 core: word queue in front of a one-round-per-cycle compression engine.
// An aligned four-byte word is fetched, written whole and closed; any other word is written byte by byte.
// Every full 64-byte block is compressed before the next word is taken from the queue.
// After a last word come a marker byte, zero bytes and the 64-bit length, one or two compressions, then five words.
// Synchronous active-high reset empties the queue and loads the initial chaining values.
module sha1_hash_core_unit #(
   parameter int QueueDepth = shc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  shc_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   output shc_pkg::rsp_type rsp_data,
   input  logic             rsp_pop
);
   logic              item_valid, item_take;
   shc_pkg::item_type item;

   // Front: queue of classified words.
   shc_front #(.Depth(QueueDepth)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .word_in    (req_data),
      .full       (req_full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // Back: packing, padding, compression and digest output.
   shc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data),
      .rsp_pop    (rsp_pop)
   );

endmodule

>>> design/shc_checker.sv
// Port-level checker for the hash core and its bind to the top level.
`include "sha1_hash_core_unit_defines.svh"

module shc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input shc_pkg::req_type req_data,
   input logic             req_full,
   input logic             rsp_empty,
   input shc_pkg::rsp_type rsp_data,
   input logic             rsp_pop
);
   // The fifth digest word carries index four.
   `SHC_ASSERT_NOW(a_last_index, clock, reset, !rsp_empty && rsp_data.last_result, rsp_data.word_index == 3'd4)

   // Taking the fifth word ends the digest.
   `SHC_ASSERT_NEXT(a_last_ends, clock, reset, rsp_pop && !rsp_empty && rsp_data.last_result, rsp_empty)

   // Words of one digest follow with consecutive indexes.
   `SHC_ASSERT_NEXT(a_index_step, clock, reset, rsp_pop && !rsp_empty && !rsp_data.last_result, !rsp_empty && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)

   // A waiting word holds until taken.
   `SHC_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

endmodule

bind sha1_hash_core_unit shc_checker u_shc_checker (.*);
